// ===== design/assert_macros.svh =====
// Assertion macros shared by the URL codec RTL.
// Simulation gets concurrent assertions; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define URLPC_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Checks that a condition is followed by a consequence in the next cycle.
`define URLPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define URLPC_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define URLPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/urlpc_pkg.sv =====
// Types, constants and character functions of the URL percent codec.
// Used by the front, queue, back and top-level modules; depends on nothing.
package urlpc_pkg;

  // Register map: word index of each register.
  localparam logic REG_DIRECTION = 1'b0;

  // Character constants.
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Kind of work handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_SINGLE   = 2'd0,  // one byte as given
    CMD_HEX      = 2'd1,  // '%' and two upper-case hex digits of the byte
    CMD_PCT_THEN = 2'd2   // a literal '%' and then the byte
  } cmd_kind_t;

  // One queued word of work.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // Decoder escape progress.
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_FIRST = 2'd2
  } esc_phase_t;

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  // Upper-case hex character of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = {4'd0, nib} + 8'h30;
    end else begin
      ch = {4'd0, nib} + 8'h37;
    end
    return ch;
  endfunction

  // Bytes that pass the encoder unchanged.
  function automatic logic passes_plain(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h5F ||
           c == 8'h21 || c == 8'h27 || c == 8'h28 || c == 8'h29 ||
           c == 8'h2A || c == 8'h7E || c == 8'h2E;
  endfunction

  // Value of an escape from its two held bytes, as a base-16 parse gives it.
  function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] ha;
    logic [4:0] hb;
    logic [7:0] v;
    ha = hex_value(a);
    hb = hex_value(b);
    v  = 8'd0;
    if (ha[4]) begin
      v = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
    end else if (hb[4]) begin
      if (a == CHAR_SPACE || (a >= 8'h09 && a <= 8'h0D) || a == CHAR_PLUS) begin
        v = {4'd0, hb[3:0]};
      end else if (a == CHAR_MINUS) begin
        v = 8'd0 - {4'd0, hb[3:0]};
      end
    end
    return v;
  endfunction

endpackage

// ===== design/urlpc_front.sv =====
// Front end of the URL codec: accepts input words, tracks escapes, queues work.
// Depends on urlpc_pkg.
module urlpc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            direction,
  input  logic            cfg_clear,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            in_is_last,
  input  logic            q_full,
  output logic            push,
  output urlpc_pkg::cmd_t push_cmd
);
  import urlpc_pkg::*;

  esc_phase_t phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic       accept;
  logic [7:0] conv;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign conv     = (in_data_byte == CHAR_PLUS) ? CHAR_SPACE : in_data_byte;

  // Escape state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ESC_NONE;
      first_r <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
    end
  end

  // Classify the accepted word and decide what the back end must emit.
  always_comb begin
    phase_nxt     = phase_r;
    first_nxt     = first_r;
    push          = 1'b0;
    push_cmd.kind = CMD_SINGLE;
    push_cmd.data = conv;
    push_cmd.last = in_is_last;
    if (cfg_clear) begin
      phase_nxt = ESC_NONE;
      first_nxt = 8'd0;
    end else if (accept) begin
      if (direction) begin
        push          = 1'b1;
        push_cmd.data = in_data_byte;
        push_cmd.kind = passes_plain(in_data_byte) ? CMD_SINGLE : CMD_HEX;
      end else begin
        unique case (phase_r)
          ESC_FIRST: begin
            push          = 1'b1;
            push_cmd.data = escape_value(first_r, in_data_byte);
            phase_nxt     = ESC_NONE;
            first_nxt     = 8'd0;
          end
          ESC_PCT: begin
            if (!in_is_last) begin
              first_nxt = in_data_byte;
              phase_nxt = ESC_FIRST;
            end else begin
              // A short escape: the '%' goes out literally before this byte.
              push          = 1'b1;
              push_cmd.kind = CMD_PCT_THEN;
              phase_nxt     = ESC_NONE;
            end
          end
          ESC_NONE: begin
            if (in_data_byte == CHAR_PCT && !in_is_last) begin
              phase_nxt = ESC_PCT;
            end else begin
              push = 1'b1;
            end
          end
          default: begin
            phase_nxt = ESC_NONE;
          end
        endcase
      end
      // The end of a string drops any escape state.
      if (in_is_last) begin
        phase_nxt = ESC_NONE;
        first_nxt = 8'd0;
      end
    end
  end

endmodule

// ===== design/urlpc_queue.sv =====
// Two-word queue between the front and back ends of the URL codec.
// Depends on urlpc_pkg.
module urlpc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  urlpc_pkg::cmd_t push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output urlpc_pkg::cmd_t head
);
  import urlpc_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = slot_r[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== design/urlpc_back.sv =====
// Back end of the URL codec: expands queued work into output words.
// Depends on urlpc_pkg.
module urlpc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  urlpc_pkg::cmd_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_run_end
);
  import urlpc_pkg::*;

  logic [1:0] sub_r, sub_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r, run_end_r;
  logic       load;
  logic [7:0] cur_byte;
  logic       cur_final;

  assign load        = head_valid && (!valid_r || out_ready);
  assign pop         = load && cur_final;
  assign out_valid   = valid_r;
  assign out_byte    = byte_r;
  assign out_last    = last_r;
  assign out_run_end = run_end_r;

  // Pick the byte at the current position within the head word.
  always_comb begin
    cur_byte  = head.data;
    cur_final = 1'b1;
    unique case (head.kind)
      CMD_SINGLE: begin
        cur_byte  = head.data;
        cur_final = 1'b1;
      end
      CMD_HEX: begin
        cur_final = (sub_r == 2'd2);
        if (sub_r == 2'd0) begin
          cur_byte = CHAR_PCT;
        end else if (sub_r == 2'd1) begin
          cur_byte = hex_char(head.data[7:4]);
        end else begin
          cur_byte = hex_char(head.data[3:0]);
        end
      end
      CMD_PCT_THEN: begin
        cur_final = (sub_r == 2'd1);
        cur_byte  = (sub_r == 2'd0) ? CHAR_PCT : head.data;
      end
      default: begin
        cur_final = 1'b1;
      end
    endcase
  end

  // Position counter and output valid.
  always_comb begin
    sub_nxt   = sub_r;
    valid_nxt = valid_r;
    if (load) begin
      sub_nxt   = cur_final ? 2'd0 : sub_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      sub_r   <= sub_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= cur_byte;
      last_r    <= cur_final && head.last;
      run_end_r <= cur_final;
    end
  end

endmodule

// ===== design/url_percent_codec.sv =====
// URL percent codec: accepts one input byte per cycle while the queue has room and
// emits one output byte per cycle while out_ready is high. Encoding gives one
// output word for a plain byte and three for an escaped one, which the single-byte
// output register sends in turn; decoding takes one word per cycle while the queue
// has room and gives at most two words per input. A two-word queue lets the input
// side keep accepting while output stalls, until the queue fills. Writing the
// direction register also discards any escape being collected. Top level; depends
// on urlpc_pkg, urlpc_front, urlpc_queue, urlpc_back and assert_macros.svh.
`include "assert_macros.svh"
module url_percent_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_run_end
);
  import urlpc_pkg::*;

  logic direction_r, direction_nxt;
  logic dir_wr;
  logic q_full, q_push, q_pop, q_head_valid;
  cmd_t q_push_cmd, q_head;

  // Configuration register access.
  assign pready = 1'b1;
  assign dir_wr = psel && penable && pwrite && (paddr[2] == REG_DIRECTION);
  assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, direction_r} : 32'd0;

  always_comb begin
    direction_nxt = dir_wr ? pwdata[0] : direction_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
    end else begin
      direction_r <= direction_nxt;
    end
  end

  urlpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .direction    (direction_r),
    .cfg_clear    (dir_wr),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_is_last   (in_is_last),
    .q_full       (q_full),
    .push         (q_push),
    .push_cmd     (q_push_cmd)
  );

  urlpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  urlpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_run_end (out_run_end)
  );

  // The end of a string always closes the run of its last input word.
  `URLPC_ASSERT_ALWAYS(a_last_ends_run, clk, rst_n, !(out_valid && out_last && !out_run_end), "out_last without out_run_end")
  // In decode mode only a literal '%' can be followed by more words of the same run.
  `URLPC_ASSERT_ALWAYS(a_dec_midrun_pct, clk, rst_n, !(out_valid && !out_run_end && !direction_r && out_byte != CHAR_PCT), "decode run continues after a non-percent word")
  // In encode mode a taken '%' is followed at once by another valid word of its run (its first hex digit).
  `URLPC_ASSERT_NEXT(a_enc_hex_follows, clk, rst_n, out_valid && out_ready && direction_r && !out_run_end && out_byte == CHAR_PCT, out_valid && !out_run_end, "encoded escape did not continue")

endmodule

// ===== test/url_percent_codec_tb.sv =====
// Self-checking testbench for url_percent_codec: directed and random byte strings in
// both directions, random idling on both channels, and direction writes over the APB port.
// Depends on urlpc_pkg and the url_percent_codec RTL.
module url_percent_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urlpc_pkg::*;

  localparam logic [2:0] DIRECTION_ADDR = {REG_DIRECTION, 2'b00};
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_WORDS = 96;
  localparam int PHASE_WORDS = 24;

  // One output word of the converted string.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       run_end;
  } codec_word_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_run_end;

  // Predictor state: its own copy of the direction and the escape in progress.
  logic        mode_encode;
  esc_phase_t  esc_state;
  logic [7:0]  held_byte;

  codec_word_t expected_words[$];
  logic [7:0]  pending_text[$];
  int          error_count;
  int          idle_cycles;
  int          stall_left;
  int          words_sent;
  logic        no_idle;

  url_percent_codec uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_byte(in_data_byte),
    .in_is_last  (in_is_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_run_end (out_run_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append one byte to the string waiting to be sent.
  function automatic void append_text_byte(input logic [7:0] b);
    pending_text = {pending_text, b};
  endfunction

  // Value of a hex digit, or -1 when the byte is not one.
  function automatic int digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'("0" + nib) : 8'("A" + nib - 4'd10);
  endfunction

  // Letters, digits and the marks that the encoder leaves alone.
  function automatic logic is_unreserved(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == CHAR_MINUS || c == "_" || c == "!" || c == "'" || c == "(" ||
           c == ")" || c == "*" || c == "~" || c == ".";
  endfunction

  // Byte that a base-16 parse of the two held escape bytes yields.
  function automatic logic [7:0] escape_result(input logic [7:0] a, input logic [7:0] b);
    int da;
    int db;
    da = digit_of(a);
    db = digit_of(b);
    if (da >= 0) return (db >= 0) ? 8'(da * 16 + db) : 8'(da);
    if (db < 0) return 8'd0;
    if (a == CHAR_SPACE || (a >= 8'h09 && a <= 8'h0D) || a == CHAR_PLUS) return 8'(db);
    if (a == CHAR_MINUS) return 8'(256 - db);
    return 8'd0;
  endfunction

  // Work out the output words that one accepted input word causes.
  task automatic predict_conversion(input logic [7:0] c, input logic last);
    logic [7:0]  conv[3];
    int          n;
    codec_word_t w;
    n = 0;
    if (mode_encode) begin
      if (is_unreserved(c)) begin
        conv[0] = c;
        n = 1;
      end else begin
        conv[0] = CHAR_PCT;
        conv[1] = nibble_char(c[7:4]);
        conv[2] = nibble_char(c[3:0]);
        n = 3;
      end
    end else if (esc_state == ESC_FIRST) begin
      conv[0] = escape_result(held_byte, c);
      n = 1;
      esc_state = ESC_NONE;
      held_byte = 8'd0;
    end else if (esc_state == ESC_PCT && !last) begin
      held_byte = c;
      esc_state = ESC_FIRST;
    end else begin
      // A percent sign cut short by the end of the string comes out literally.
      if (esc_state == ESC_PCT) begin
        conv[n] = CHAR_PCT;
        n++;
        esc_state = ESC_NONE;
      end
      if (c == CHAR_PCT && !last) begin
        esc_state = ESC_PCT;
      end else if (c == CHAR_PLUS) begin
        conv[n] = CHAR_SPACE;
        n++;
      end else begin
        conv[n] = c;
        n++;
      end
    end
    if (last) begin
      esc_state = ESC_NONE;
      held_byte = 8'd0;
    end
    for (int i = 0; i < n; i++) begin
      w.data = conv[i];
      w.run_end = (i == n - 1);
      w.last = last && (i == n - 1);
      expected_words = {expected_words, w};
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Mostly no idle, otherwise a short idle stretch, now and then a long one.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one input word; called and returning at a falling edge.
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_is_last <= last;
    do @(posedge clk); while (!in_ready);
    predict_conversion(b, last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      append_text_byte(s[i]);
    end
  endtask

  // Send the buffered string, optionally marking its final byte as the end.
  task automatic send_text(input logic mark_last);
    for (int i = 0; i < pending_text.size(); i++) begin
      send_word(pending_text[i], mark_last && (i == pending_text.size() - 1));
    end
    pending_text.delete();
  endtask

  // Hold off the sender until every expected word has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Make sure the block is idle, including any escape held without output.
  task automatic settle_block();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_direction(input logic value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DIRECTION_ADDR;
    pwdata <= {31'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mode_encode = value;
    esc_state = ESC_NONE;
    held_byte = 8'd0;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Byte mix that exercises the decoder: digits, escapes, signs, spaces and noise.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 15);
    if (r < 5) begin
      return nibble_char(4'($urandom_range(0, 15))) |
             ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    end
    if (r == 5) return CHAR_PCT;
    if (r == 6) return CHAR_PLUS;
    if (r == 7) return CHAR_MINUS;
    if (r == 8) return $urandom_range(0, 5) == 0 ? CHAR_SPACE : 8'($urandom_range(9, 13));
    if (r < 12) return 8'($urandom_range(int'("a"), int'("z")));
    return 8'($urandom_range(0, 255));
  endfunction

  // Random string: picked characters mixed with mostly well-formed escapes, some pure noise.
  task automatic fill_random_text();
    int len;
    len = $urandom_range(1, 8);
    if ($urandom_range(0, 7) == 0) begin
      repeat (len) append_text_byte(8'($urandom_range(0, 255)));
    end else begin
      while (pending_text.size() < len) begin
        if ($urandom_range(0, 2) == 0) begin
          append_text_byte(CHAR_PCT);
          append_text_byte($urandom_range(0, 3) != 0 ?
                           nibble_char(4'($urandom_range(0, 15))) : pick_char());
          append_text_byte($urandom_range(0, 3) != 0 ?
                           nibble_char(4'($urandom_range(0, 15))) : pick_char());
        end else begin
          append_text_byte(pick_char());
        end
      end
    end
  endtask

  // Escapes of every kind and the plus sign, at the reset direction (decode).
  task automatic test_decode_directed();
    add_text("%41");
    send_text(1'b1);
    add_text("%4g");
    send_text(1'b1);
    add_text("% c");
    send_text(1'b1);
    add_text("%-1");
    send_text(1'b1);
    add_text("%zz");
    send_text(1'b1);
    // A percent sign with only one byte, or none, before the end.
    add_text("%A");
    send_text(1'b1);
    add_text("%");
    send_text(1'b1);
    add_text("+");
    append_text_byte(8'h00);
    append_text_byte(8'hFF);
    send_text(1'b1);
  endtask

  // Plain bytes, marks and bytes that need escaping, at both byte extremes.
  task automatic test_encode_directed();
    settle_block();
    write_direction(1'b1);
    add_text("a~");
    append_text_byte(8'h00);
    append_text_byte(8'hFF);
    send_text(1'b1);
  endtask

  // A direction write discards an escape still being collected.
  task automatic test_direction_clears_escape();
    settle_block();
    write_direction(1'b0);
    add_text("%4");
    send_text(1'b0);
    settle_block();
    write_direction(1'b0);
    add_text("1");
    send_text(1'b1);
  endtask

  // Random strings over several direction phases, with a no-idle phase and a pause.
  task automatic test_random_traffic();
    int phase;
    int phase_start;
    phase = 0;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      settle_block();
      write_direction(phase == 0 ? 1'b1 : (phase == 1 ? 1'b0 : 1'($urandom_range(0, 1))));
      no_idle = (phase == 2);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        fill_random_text();
        send_text(1'b1);
        if (phase == 3 && words_sent - phase_start >= PHASE_WORDS / 2 && stall_left == 0) begin
          wait_for_results();
        end
      end
      no_idle = 1'b0;
      phase++;
    end
  endtask

  // Receiver: random stalls, none while a no-idle phase runs.
  always @(negedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left = pick_idle_len();
    end
  end

  // Check each accepted output word against the oldest expected one.
  always @(posedge clk) begin
    codec_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_byte, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (out_last !== want.last) report_mismatch("out_last", out_last, want.last);
        if (out_run_end !== want.run_end) begin
          report_mismatch("out_run_end", out_run_end, want.run_end);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_data_byte = 8'd0;
    in_is_last = 1'b0;
    mode_encode = 1'b0;
    esc_state = ESC_NONE;
    held_byte = 8'd0;
    error_count = 0;
    words_sent = 0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_decode_directed();
    test_encode_directed();
    test_direction_clears_escape();
    test_random_traffic();

    settle_block();
    if (expected_words.size() != 0) begin
      report_mismatch("words never produced", 0, expected_words.size());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/urlpc_pkg.sv
design/urlpc_front.sv
design/urlpc_queue.sv
design/urlpc_back.sv
design/url_percent_codec.sv
test/url_percent_codec_tb.sv
